@@ sv/gbpf_pkg.sv @@
// Package: sizes, types and state codes of the grid broadphase pair finder.
`default_nettype none
package gbpf_pkg;

   localparam int MAX_BODIES = 64;
   localparam int IDX_W      = $clog2(MAX_BODIES);
   localparam int CNT_W      = IDX_W + 1;
   localparam int OUT_IDX_W  = 6;
   localparam int COORD_W    = 32;
   localparam int RADIUS_W   = 31;
   localparam int CSR_W      = 32;
   localparam int CELL_W     = 32;
   localparam int PROD_W     = 2 * CSR_W;

   localparam logic [CSR_W-1:0] INV_RESET = CSR_W'(65536);

   typedef logic signed [CELL_W-1:0] cell_type;

   localparam cell_type CELL_MAX = {1'b0, {(CELL_W-1){1'b1}}};
   localparam cell_type CELL_MIN = {1'b1, {(CELL_W-1){1'b0}}};

   typedef struct packed {
      cell_type lx;
      cell_type hx;
      cell_type ly;
      cell_type hy;
   } entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MUL,
      ST_FIN,
      ST_SCAN,
      ST_FLUSH
   } state_type;

   // Step order of the shared multiplier: x low, x high, y low, y high.
   localparam logic [1:0] STEP_LAST = 2'd3;

endpackage
`default_nettype wire

@@ sv/gbpf_if.sv @@
// Interfaces: body request channel and pair response channel.
`default_nettype none
interface gbpf_req_if;
   import gbpf_pkg::*;
   logic                        valid;
   logic                        ready;
   logic                        new_frame;
   logic signed [COORD_W-1:0]   center_x;
   logic signed [COORD_W-1:0]   center_y;
   logic        [RADIUS_W-1:0]  body_radius;
   modport source (output valid, output new_frame, output center_x, output center_y,
                   output body_radius, input ready);
   modport sink   (input valid, input new_frame, input center_x, input center_y,
                   input body_radius, output ready);
endinterface

interface gbpf_rsp_if;
   import gbpf_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [OUT_IDX_W-1:0]  first_index;
   logic [OUT_IDX_W-1:0]  second_index;
   logic                  last_pair;
   modport source (output valid, output first_index, output second_index,
                   output last_pair, input ready);
   modport sink   (input valid, input first_index, input second_index,
                   input last_pair, output ready);
endinterface
`default_nettype wire

@@ sv/grid_broadphase_pair_finder.sv @@
// Top level: uniform grid broadphase, one shared multiplier and a serial pair scan.
// Usage: bodies enter on req_bus (center, radius, new_frame) one transaction at a
// time; req_bus.ready is high only while the block is idle. Each body is given the
// next index and its cell range in x and y, computed by one shared 32x32
// multiplier over four multiply/round steps. It is then compared with each
// stored body, one stored cell range per cycle read from the cell memory while
// the scan does not hold, and each overlap leaves as a pair (earlier, new) on
// rsp_bus, last one flagged. Pairs go through a single output register; while
// the receiver stalls, the scan holds when a new pair is found while one pair
// waits and the output register is still full. A zero inverse_cell_size stores
// the body but skips the scan. A body arriving with the store full is dropped
// at once with no pair. csr_wr_en writes inverse_cell_size; write it only while
// idle. Synchronous reset empties the store, clears the output register and
// restores cell size 1.0.
`default_nettype none
module grid_broadphase_pair_finder (
   input  wire logic                      clock,
   input  wire logic                      reset,
   gbpf_req_if.sink                       req_bus,
   gbpf_rsp_if.source                     rsp_bus,
   input  wire logic                      csr_wr_en,
   input  wire logic [gbpf_pkg::CSR_W-1:0] csr_wr_data
);
   import gbpf_pkg::*;

   state_type                  state_ff, state_in;
   logic [CSR_W-1:0]           inv_ff;
   logic [CNT_W-1:0]           count_ff, count_in;
   logic [1:0]                 step_ff, step_in;
   logic [CNT_W-1:0]           rd_ptr_ff, rd_ptr_in;
   logic                       cmp_valid_ff, cmp_valid_in;
   logic [IDX_W-1:0]           cmp_ptr_ff, cmp_ptr_in;
   logic                       pend_valid_ff, pend_valid_in;
   logic [IDX_W-1:0]           pend_ptr_ff, pend_ptr_in;

   logic signed [COORD_W-1:0]  cx_ff, cy_ff;
   logic [RADIUS_W-1:0]        r_ff;
   logic [PROD_W-1:0]          prod_ff;
   logic                       neg_ff;
   cell_type                   cell_ff [4];

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [OUT_IDX_W-1:0]       rsp_first_ff, rsp_second_ff;
   logic                       rsp_last_ff;

   entry_type                  mem [MAX_BODIES];
   entry_type                  rd_data_ff;
   entry_type                  wr_entry;

   logic                       load_body;
   logic                       mem_rd_en, mem_wr_en;
   logic                       push, push_last;
   logic [IDX_W-1:0]           push_first;
   logic                       out_free, hit, stall;

   logic signed [COORD_W-1:0]  op_c;
   logic signed [COORD_W:0]    op_s;
   logic [COORD_W-1:0]         op_mag;
   logic [COORD_W-1:0]         q_pos;
   logic [PROD_W:0]            q_sum;
   logic [COORD_W:0]           q_neg;
   cell_type                   cell_val;

   // Shared multiplier operand: center plus or minus radius, as sign and magnitude.
   always_comb begin
      op_c   = step_ff[1] ? cy_ff : cx_ff;
      op_s   = step_ff[0] ? (COORD_W+1)'(op_c) + $signed({2'b00, r_ff})
                          : (COORD_W+1)'(op_c) - $signed({2'b00, r_ff});
      op_mag = op_s[COORD_W] ? COORD_W'(-op_s) : op_s[COORD_W-1:0];
   end

   // Round the product toward minus infinity and saturate to the cell range.
   always_comb begin
      q_pos = prod_ff[PROD_W-1:COORD_W];
      q_sum = {1'b0, prod_ff} + (PROD_W+1)'({COORD_W{1'b1}});
      q_neg = q_sum[PROD_W:COORD_W];
      if (!neg_ff) begin
         cell_val = q_pos[COORD_W-1] ? CELL_MAX : cell_type'(q_pos);
      end else if (q_neg[COORD_W] || q_neg[COORD_W-1]) begin
         cell_val = CELL_MIN;
      end else begin
         cell_val = cell_type'(-q_neg[CELL_W-1:0]);
      end
   end

   assign out_free = !rsp_valid_ff || rsp_bus.ready;
   assign hit = (rd_data_ff.lx <= cell_ff[1]) && (cell_ff[0] <= rd_data_ff.hx) &&
                (rd_data_ff.ly <= cell_ff[3]) && (cell_ff[2] <= rd_data_ff.hy);
   assign stall = cmp_valid_ff && hit && pend_valid_ff && !out_free;
   assign wr_entry = '{lx: cell_ff[0], hx: cell_ff[1], ly: cell_ff[2], hy: cell_ff[3]};

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      step_in       = step_ff;
      rd_ptr_in     = rd_ptr_ff;
      cmp_valid_in  = cmp_valid_ff;
      cmp_ptr_in    = cmp_ptr_ff;
      pend_valid_in = pend_valid_ff;
      pend_ptr_in   = pend_ptr_ff;
      load_body     = 1'b0;
      mem_rd_en     = 1'b0;
      mem_wr_en     = 1'b0;
      push          = 1'b0;
      push_last     = 1'b0;
      push_first    = pend_ptr_ff;
      req_bus.ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_bus.ready = 1'b1;
            if (req_bus.valid) begin
               load_body = 1'b1;
               if (req_bus.new_frame) begin
                  count_in = '0;
               end
               // drop the body when the store is full
               if (req_bus.new_frame || count_ff < CNT_W'(MAX_BODIES)) begin
                  state_in = ST_MUL;
                  step_in  = '0;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (step_ff == STEP_LAST) begin
               rd_ptr_in    = '0;
               cmp_valid_in = 1'b0;
               state_in     = (inv_ff == '0) ? ST_FLUSH : ST_SCAN;
            end else begin
               step_in  = step_ff + 2'd1;
               state_in = ST_MUL;
            end
         end
         ST_SCAN: begin
            if (!stall) begin
               if (cmp_valid_ff && hit) begin
                  // hold the newest hit; release the older one as a non-final pair
                  pend_ptr_in   = cmp_ptr_ff;
                  pend_valid_in = 1'b1;
                  push          = pend_valid_ff;
               end
               if (rd_ptr_ff < count_ff) begin
                  mem_rd_en    = 1'b1;
                  cmp_ptr_in   = rd_ptr_ff[IDX_W-1:0];
                  cmp_valid_in = 1'b1;
                  rd_ptr_in    = rd_ptr_ff + CNT_W'(1);
               end else begin
                  cmp_valid_in = 1'b0;
                  if (!cmp_valid_ff) begin
                     state_in = ST_FLUSH;
                  end
               end
            end
         end
         ST_FLUSH: begin
            if (!pend_valid_ff || out_free) begin
               push          = pend_valid_ff;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               mem_wr_en     = 1'b1;
               count_in      = count_ff + CNT_W'(1);
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = push ? 1'b1 : (rsp_bus.ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         inv_ff        <= INV_RESET;
         count_ff      <= '0;
         step_ff       <= '0;
         rd_ptr_ff     <= '0;
         cmp_valid_ff  <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         if (csr_wr_en) begin
            inv_ff <= csr_wr_data;
         end
         count_ff      <= count_in;
         step_ff       <= step_in;
         rd_ptr_ff     <= rd_ptr_in;
         cmp_valid_ff  <= cmp_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmp_ptr_ff  <= cmp_ptr_in;
      pend_ptr_ff <= pend_ptr_in;
      if (load_body) begin
         cx_ff <= req_bus.center_x;
         cy_ff <= req_bus.center_y;
         r_ff  <= req_bus.body_radius;
      end
      if (state_ff == ST_MUL) begin
         prod_ff <= PROD_W'(op_mag) * PROD_W'(inv_ff);
         neg_ff  <= op_s[COORD_W];
      end
      if (state_ff == ST_FIN) begin
         cell_ff[step_ff] <= cell_val;
      end
      if (push) begin
         rsp_first_ff  <= OUT_IDX_W'(push_first);
         rsp_second_ff <= OUT_IDX_W'(count_ff);
         rsp_last_ff   <= push_last;
      end
   end

   // Cell range memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (mem_wr_en) begin
         mem[count_ff[IDX_W-1:0]] <= wr_entry;
      end
      if (mem_rd_en) begin
         rd_data_ff <= mem[rd_ptr_ff[IDX_W-1:0]];
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.first_index  = rsp_first_ff;
   assign rsp_bus.second_index = rsp_second_ff;
   assign rsp_bus.last_pair    = rsp_last_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_BODIES))
      else $error("stored body count exceeds capacity");

   a_no_pending_idle: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE) |-> !pend_valid_ff)
      else $error("pair left pending after body completed");

   a_cmp_in_store: assert property (@(posedge clock) disable iff (reset)
      cmp_valid_ff |-> (CNT_W'(cmp_ptr_ff) < count_ff))
      else $error("scan compared an entry beyond the stored bodies");

   a_push_second: assert property (@(posedge clock) disable iff (reset)
      push |=> (rsp_bus.first_index < rsp_bus.second_index))
      else $error("pair indices out of order");
`endif

endmodule
`default_nettype wire

@@ verif/grid_broadphase_pair_finder_check.sv @@
// Checker: watches body and pair transactions, predicts candidate pairs and compares them.
module grid_broadphase_pair_finder_check (
   input  wire logic                       clock,
   input  wire logic                       reset,
   gbpf_req_if                             req_bus,
   gbpf_rsp_if                             rsp_bus,
   input  wire logic                       csr_wr_en,
   input  wire logic [gbpf_pkg::CSR_W-1:0] csr_wr_data,
   output int                              mismatch_count,
   output int                              pairs_owed
);
   timeunit 1ns;
   timeprecision 1ps;
   import gbpf_pkg::*;

   typedef struct packed {
      logic [OUT_IDX_W-1:0] first_index;
      logic [OUT_IDX_W-1:0] second_index;
      logic                 last_pair;
   } pair_type;

   pair_type         owed_pairs[$];
   logic [CSR_W-1:0] inv_size;
   int unsigned      body_count;
   entry_type        body_cells[MAX_BODIES];

   // floor(s * inv / 2^32), saturated to the signed cell range
   function automatic cell_type cell_coord(input longint s, input logic [CSR_W-1:0] inv);
      logic [63:0] mag;
      logic [64:0] prod;
      logic [64:0] q;
      cell_type    neg;
      mag  = (s < 0) ? 64'(-s) : 64'(s);
      prod = 65'(mag) * 65'(inv);
      if (s >= 0) begin
         q = prod >> 32;
         if (q > 65'h7FFF_FFFF) return CELL_MAX;
         return cell_type'(q[31:0]);
      end
      q = (prod + 65'hFFFF_FFFF) >> 32;
      if (q >= 65'h8000_0000) return CELL_MIN;
      neg = q[31:0];
      return -neg;
   endfunction

   function automatic bit shares_cell(input entry_type a, input entry_type b);
      return a.lx <= b.hx && b.lx <= a.hx && a.ly <= b.hy && b.ly <= a.hy;
   endfunction

   function automatic void add_body(input logic frame, input longint cx, input longint cy,
                                    input longint rad);
      entry_type fresh;
      pair_type  owed;
      int        last_hit;
      if (frame) body_count = 0;
      // drop the body when the store is full
      if (body_count >= MAX_BODIES) return;
      fresh.lx = cell_coord(cx - rad, inv_size);
      fresh.hx = cell_coord(cx + rad, inv_size);
      fresh.ly = cell_coord(cy - rad, inv_size);
      fresh.hy = cell_coord(cy + rad, inv_size);
      if (inv_size != '0) begin
         last_hit = -1;
         for (int k = 0; k < body_count; k++)
            if (shares_cell(body_cells[k], fresh)) last_hit = k;
         for (int k = 0; k <= last_hit; k++)
            if (shares_cell(body_cells[k], fresh)) begin
               owed = '{first_index:  OUT_IDX_W'(k),
                        second_index: OUT_IDX_W'(body_count),
                        last_pair:    (k == last_hit)};
               owed_pairs = {owed_pairs, owed};
            end
      end
      body_cells[body_count] = fresh;
      body_count++;
   endfunction

   always @(posedge clock) begin
      pair_type got;
      pair_type want;
      if (reset) begin
         body_count     = 0;
         inv_size       = INV_RESET;
         mismatch_count = 0;
         owed_pairs.delete();
      end else begin
         if (csr_wr_en) inv_size = csr_wr_data;
         if (rsp_bus.valid && rsp_bus.ready) begin
            got = '{rsp_bus.first_index, rsp_bus.second_index, rsp_bus.last_pair};
            if (owed_pairs.size() == 0) begin
               $display("%0t: pair with none expected, actual (%0d,%0d) last %0b",
                        $realtime, got.first_index, got.second_index, got.last_pair);
               mismatch_count++;
            end else begin
               want = owed_pairs.pop_front();
               if (got.first_index != want.first_index) begin
                  $display("%0t: first_index expected %0d actual %0d",
                           $realtime, want.first_index, got.first_index);
                  mismatch_count++;
               end
               if (got.second_index != want.second_index) begin
                  $display("%0t: second_index expected %0d actual %0d",
                           $realtime, want.second_index, got.second_index);
                  mismatch_count++;
               end
               if (got.last_pair != want.last_pair) begin
                  $display("%0t: last_pair expected %0b actual %0b",
                           $realtime, want.last_pair, got.last_pair);
                  mismatch_count++;
               end
            end
         end
         if (req_bus.valid && req_bus.ready)
            add_body(req_bus.new_frame, req_bus.center_x, req_bus.center_y,
                     req_bus.body_radius);
      end
      pairs_owed = owed_pairs.size();
   end

endmodule

@@ verif/grid_broadphase_pair_finder_test.sv @@
// Testbench top: clock, reset, body stimulus, cell size settings and the verdict.
module grid_broadphase_pair_finder_test;
   timeunit 1ns;
   timeprecision 1ps;
   import gbpf_pkg::*;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             csr_wr_en = 1'b0;
   logic [CSR_W-1:0] csr_wr_data = '0;
   int               pair_errors;
   int               pairs_owed;
   int               send_gap_pct = 6;
   int               stall_pct = 54;

   gbpf_req_if req_bus();
   gbpf_rsp_if rsp_bus();

   grid_broadphase_pair_finder uut (
      .clock       (clock),
      .reset       (reset),
      .req_bus     (req_bus),
      .rsp_bus     (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   grid_broadphase_pair_finder_check pair_check (
      .clock          (clock),
      .reset          (reset),
      .req_bus        (req_bus),
      .rsp_bus        (rsp_bus),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .mismatch_count (pair_errors),
      .pairs_owed     (pairs_owed)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_bus.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Starts and ends at a falling edge; valid stays high when no gap follows.
   task automatic send_body(input logic frame, input logic [COORD_W-1:0] cx,
                            input logic [COORD_W-1:0] cy, input logic [RADIUS_W-1:0] rad);
      while ($urandom_range(0, 99) < send_gap_pct) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid       <= 1'b1;
      req_bus.new_frame   <= frame;
      req_bus.center_x    <= cx;
      req_bus.center_y    <= cy;
      req_bus.body_radius <= rad;
      forever begin
         @(posedge clock);
         if (req_bus.ready) break;
      end
      @(negedge clock);
   endtask

   // Hold off until every pair has drained and the block is back to idle.
   task automatic settle();
      req_bus.valid <= 1'b0;
      while (pairs_owed != 0) @(negedge clock);
      repeat (100) @(negedge clock);
   endtask

   task automatic write_inv(input logic [CSR_W-1:0] value);
      settle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
   endtask

   task automatic run_segment(input logic [CSR_W-1:0] inv, input int count,
                              input int frame_pct);
      longint             cell_units;
      longint             span;
      longint             rad_max;
      logic [COORD_W-1:0] cx;
      logic [COORD_W-1:0] cy;
      logic [RADIUS_W-1:0] rad;
      logic               frame;
      write_inv(inv);
      cell_units = (inv == '0) ? 64'd65536 : 64'h1_0000_0000 / inv;
      span       = cell_units * 4;
      rad_max    = cell_units * 3 / 2;
      if (span > 64'h7FFF_FFFF) span = 64'h7FFF_FFFF;
      if (rad_max > 64'h7FFF_FFFF) rad_max = 64'h7FFF_FFFF;
      repeat (count) begin
         frame = ($urandom_range(0, 99) < frame_pct);
         if ($urandom_range(0, 9) == 0) begin
            cx  = $urandom;
            cy  = $urandom;
            rad = RADIUS_W'($urandom);
         end else begin
            // cluster bodies within a few cells so that overlaps are common
            cx  = COORD_W'(longint'($urandom_range(0, 32'(2 * span))) - span);
            cy  = COORD_W'(longint'($urandom_range(0, 32'(2 * span))) - span);
            rad = RADIUS_W'($urandom_range(0, 32'(rad_max)));
         end
         send_body(frame, cx, cy, rad);
      end
   endtask

   initial begin
      req_bus.valid       = 1'b0;
      req_bus.new_frame   = 1'b0;
      req_bus.center_x    = '0;
      req_bus.center_y    = '0;
      req_bus.body_radius = '0;
      rsp_bus.ready       = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // cell size 1.0 from reset: same cell, neighbor cells, floor of negatives
      send_body(1'b1, 32'h0000_0000, 32'h0000_0000, 31'h0000_0000);
      send_body(1'b0, 32'h0000_0000, 32'h0000_0000, 31'h0000_0000);
      send_body(1'b0, 32'h0001_0000, 32'h0000_0000, 31'h0000_0000);
      send_body(1'b0, 32'h0000_8000, 32'h0000_0000, 31'h0000_8000);
      send_body(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 31'h0000_0000);
      send_body(1'b0, 32'hFFFF_0000, 32'hFFFF_0000, 31'h0000_0000);
      send_body(1'b0, 32'h8000_0000, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_body(1'b0, 32'h7FFF_FFFF, 32'h8000_0000, 31'h7FFF_FFFF);
      send_body(1'b0, 32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF);
      send_body(1'b1, 32'h8000_0000, 32'h8000_0000, 31'h0000_0000);
      send_body(1'b0, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);

      // finest cells: ranges saturate at both ends
      write_inv(32'hFFFF_FFFF);
      send_body(1'b1, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 31'h7FFF_FFFF);
      send_body(1'b0, 32'h8000_0000, 32'h8000_0000, 31'h7FFF_FFFF);
      send_body(1'b0, 32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF);

      // zero reciprocal: bodies are stored but never paired
      write_inv(32'h0000_0000);
      send_body(1'b0, 32'h0000_0000, 32'h0000_0000, 31'h0000_0000);
      send_body(1'b0, 32'h0000_0000, 32'h0000_0000, 31'h7FFF_FFFF);

      run_segment(32'h0001_0000, 25, 10);
      run_segment(32'h0000_0000, 15, 10);
      send_gap_pct = 54;
      stall_pct    = 6;
      run_segment(32'hFFFF_FFFF, 30, 10);
      // huge cells and no frame starts: fill the store and overrun it
      run_segment(32'h0000_0001, 68, 0);
      send_gap_pct = 0;
      stall_pct    = 0;
      run_segment(32'h0004_0000, 15, 10);
      run_segment(32'h0000_4000, 15, 10);

      settle();
      if (pair_errors == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

   initial begin
      #20_000_000;
      $display("status: fail");
      $finish;
   end

endmodule
